// ----- rtl/bphd_pkg.sv -----
// shared types and constants of the button press, hold and double-press classifier
package bphd_pkg;

    // width of every per-button field of an item
    localparam int ITEM_BITS = 4;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESSED_LEVEL = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_BITS-1:0] HOLD_TICKS_RST    = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] DOUBLE_WINDOW_RST = 16'd30;
    localparam logic                     PRESSED_LEVEL_RST = 1'b0;

    // parameter defaults
    localparam int NUM_BUTTONS_DEF  = 4;
    localparam int COUNTER_BITS_DEF = 16;

    typedef struct packed {
        logic [ITEM_BITS-1:0] raw_levels;
        logic [ITEM_BITS-1:0] ack_single;
        logic [ITEM_BITS-1:0] ack_double;
    } in_item_t;

    typedef struct packed {
        logic [ITEM_BITS-1:0] single_flags;
        logic [ITEM_BITS-1:0] hold_flags;
        logic [ITEM_BITS-1:0] double_flags;
        logic [ITEM_BITS-1:0] stable_levels;
    } out_item_t;

    // configuration seen by every lane
    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] hold_ticks;
        logic [CFG_DATA_BITS-1:0] double_window_ticks;
        logic                     pressed_level;
    } cfg_t;

    // per-lane status after this tick's update
    typedef struct packed {
        logic single_flag;
        logic hold_flag;
        logic double_flag;
        logic stable_level;
    } lane_status_t;

endpackage

// ----- rtl/bphd_lane.sv -----
// one button lane: debounce history, hold and window counters, event flags
module bphd_lane #(
    parameter int COUNTER_BITS = bphd_pkg::COUNTER_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 raw,
    input  logic                 ack_single,
    input  logic                 ack_double,
    input  bphd_pkg::cfg_t       cfg,
    output bphd_pkg::lane_status_t status_next
);

    logic [2:0]              hist_reg, hist_next;
    logic                    deb_reg, deb_next;
    logic [COUNTER_BITS-1:0] hold_cnt_reg, hold_cnt_next;
    logic [COUNTER_BITS-1:0] win_cnt_reg, win_cnt_next;
    logic                    single_reg, single_next;
    logic                    hold_reg, hold_next;
    logic                    double_reg, double_next;

    logic [COUNTER_BITS-1:0] hold_load;
    logic [COUNTER_BITS-1:0] win_load;
    logic [COUNTER_BITS-1:0] hold_dec;
    logic                    agree;
    logic                    pressed;

    assign hold_load = COUNTER_BITS'(cfg.hold_ticks);
    assign win_load  = COUNTER_BITS'(cfg.double_window_ticks);

    always_comb
    begin
        hist_next     = {hist_reg[1:0], raw};
        deb_next      = deb_reg;
        hold_cnt_next = hold_cnt_reg;
        win_cnt_next  = win_cnt_reg;
        single_next   = single_reg & ~ack_single;
        hold_next     = hold_reg;
        double_next   = double_reg & ~ack_double;
        agree         = (hist_next == 3'b000) || (hist_next == 3'b111);
        pressed       = (raw == cfg.pressed_level);
        hold_dec      = (hold_cnt_reg != '0) ? hold_cnt_reg - 1'b1 : '0;

        if (agree)
        begin
            if (deb_reg != raw)
            begin
                deb_next = raw;
                if (pressed)
                begin
                    hold_cnt_next = hold_load;
                    // second press inside an open window
                    if ((win_cnt_reg != '0) && (win_cnt_reg < win_load))
                    begin
                        double_next  = 1'b1;
                        win_cnt_next = '0;
                    end
                    else
                    begin
                        win_cnt_next = win_load;
                    end
                end
                else
                begin
                    hold_next    = 1'b0;
                    win_cnt_next = (win_cnt_reg != '0) ? win_cnt_reg - 1'b1 : '0;
                end
            end
            else if (pressed)
            begin
                hold_cnt_next = hold_dec;
                // long press cancels the pending click
                if (hold_dec == '0)
                begin
                    hold_next    = 1'b1;
                    win_cnt_next = '0;
                end
            end
            else if (win_cnt_reg != '0)
            begin
                win_cnt_next = win_cnt_reg - 1'b1;
                if (win_cnt_reg == COUNTER_BITS'(1))
                begin
                    single_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg     <= {3{~bphd_pkg::PRESSED_LEVEL_RST}};
            deb_reg      <= ~bphd_pkg::PRESSED_LEVEL_RST;
            hold_cnt_reg <= '0;
            win_cnt_reg  <= '0;
            single_reg   <= 1'b0;
            hold_reg     <= 1'b0;
            double_reg   <= 1'b0;
        end
        else if (tick)
        begin
            hist_reg     <= hist_next;
            deb_reg      <= deb_next;
            hold_cnt_reg <= hold_cnt_next;
            win_cnt_reg  <= win_cnt_next;
            single_reg   <= single_next;
            hold_reg     <= hold_next;
            double_reg   <= double_next;
        end
    end

    assign status_next.single_flag  = single_next;
    assign status_next.hold_flag    = hold_next;
    assign status_next.double_flag  = double_next;
    assign status_next.stable_level = deb_next;

endmodule

// ----- rtl/button_press_hold_double_classifier.sv -----
// top level: button lanes, configuration registers, merge and output register
//
// Debounces up to four buttons and classifies single press, double press and
// long hold. Each input item is one sampling tick: raw pin levels plus
// acknowledge masks for the single and double flags. Each accepted item
// yields exactly one output item holding the flags and debounced levels
// after that tick's update.
//
// in channel (in_valid/in_ready/in_item) and out channel
// (out_valid/out_ready/out_item) use valid/ready handshakes. One lane per
// button updates its state in the cycle the item is accepted; the merged
// lane status lands in the output register, so the result is offered in the
// cycle after acceptance. Throughput is one item per cycle: in_ready stays
// high while the output register is empty or being drained. When the
// receiver stalls, the output item is held and in_ready drops until it is
// taken; nothing is lost or repeated.
// The config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; indexes past the register list are ignored. Reset (rst_n, async,
// active low) restores register defaults, clears all flags and counters and
// puts every sample history at the released level. No clearing pass.
module button_press_hold_double_classifier #(
    parameter int NUM_BUTTONS  = bphd_pkg::NUM_BUTTONS_DEF,
    parameter int COUNTER_BITS = bphd_pkg::COUNTER_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  bphd_pkg::in_item_t                    in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output bphd_pkg::out_item_t                   out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bphd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bphd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int IB = bphd_pkg::ITEM_BITS;

    // configuration registers
    bphd_pkg::cfg_t cfg_reg, cfg_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    bphd_pkg::out_item_t out_item_reg, out_item_next;

    logic in_fire;
    logic out_fire;

    bphd_pkg::lane_status_t lane_status [NUM_BUTTONS];

    logic [IB-1:0] single_v;
    logic [IB-1:0] hold_v;
    logic [IB-1:0] double_v;
    logic [IB-1:0] stable_v;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // register writes, unknown indexes ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bphd_pkg::REG_HOLD_TICKS:    cfg_next.hold_ticks          = cfg_data;
                bphd_pkg::REG_DOUBLE_WINDOW: cfg_next.double_window_ticks = cfg_data;
                bphd_pkg::REG_PRESSED_LEVEL: cfg_next.pressed_level       = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // one lane per button; buttons past the item width see level 0, no ack
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic raw_b;
        logic acks_b;
        logic ackd_b;

        if (i < IB)
        begin : g_io
            assign raw_b  = in_item.raw_levels[i];
            assign acks_b = in_item.ack_single[i];
            assign ackd_b = in_item.ack_double[i];
        end
        else
        begin : g_hidden
            assign raw_b  = 1'b0;
            assign acks_b = 1'b0;
            assign ackd_b = 1'b0;
        end

        bphd_lane #(
            .COUNTER_BITS (COUNTER_BITS)
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .tick        (in_fire),
            .raw         (raw_b),
            .ack_single  (acks_b),
            .ack_double  (ackd_b),
            .cfg         (cfg_reg),
            .status_next (lane_status[i])
        );
    end

    // merge lane status into the output fields
    for (genvar i = 0; i < IB; i++)
    begin : g_merge
        if (i < NUM_BUTTONS)
        begin : g_used
            assign single_v[i] = lane_status[i].single_flag;
            assign hold_v[i]   = lane_status[i].hold_flag;
            assign double_v[i] = lane_status[i].double_flag;
            assign stable_v[i] = lane_status[i].stable_level;
        end
        else
        begin : g_unused
            assign single_v[i] = 1'b0;
            assign hold_v[i]   = 1'b0;
            assign double_v[i] = 1'b0;
            assign stable_v[i] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (in_fire)
        begin
            out_valid_next              = 1'b1;
            out_item_next.single_flags  = single_v;
            out_item_next.hold_flags    = hold_v;
            out_item_next.double_flags  = double_v;
            out_item_next.stable_levels = stable_v;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks          <= bphd_pkg::HOLD_TICKS_RST;
            cfg_reg.double_window_ticks <= bphd_pkg::DOUBLE_WINDOW_RST;
            cfg_reg.pressed_level       <= bphd_pkg::PRESSED_LEVEL_RST;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // an accepted item always produces a result next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid)
        else $error("accepted item produced no result");

    // an empty output register never blocks the input
    a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");

    // a drained result with no new item leaves the output empty
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !in_fire) |=> !out_valid)
        else $error("result repeated after being taken");

endmodule

// ----- tb/tb_button_press_hold_double_classifier.sv -----
// self-checking testbench for the button press, hold and double-press classifier
module tb_button_press_hold_double_classifier;
    import bphd_pkg::*;

    localparam int BUTTONS        = ITEM_BITS;
    // index past the register list, the block must ignore it
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
    // cycles with no handshake on any channel before the run is given up
    localparam int WATCHDOG_LIMIT = 2000;
    // result lands in the cycle after acceptance, a little margin on top
    localparam int SETTLE_CYCLES  = 4;
    // directed opening: raw levels, one nibble per tick, first tick leftmost
    localparam int WARMUP_TICKS   = 25;
    localparam logic [4*WARMUP_TICKS-1:0] WARMUP_LEVELS = 100'hF000000FFFCCCFFFEEEFFFFFF;

    // mirror of the block: per-button debounce, counters and flags, plus the queue
    // of flag words still owed by the block
    class button_scoreboard;
        bit [15:0] hold_ticks;
        bit [15:0] window_ticks;
        bit        pressed_level;
        bit [2:0]  history    [BUTTONS];
        bit        stable     [BUTTONS];
        bit [15:0] hold_cnt   [BUTTONS];
        bit [15:0] window_cnt [BUTTONS];
        bit        single_f   [BUTTONS];
        bit        hold_f     [BUTTONS];
        bit        double_f   [BUTTONS];
        out_item_t flags_due  [$];
        int        fail_count;

        function new();
            hold_ticks    = HOLD_TICKS_RST;
            window_ticks  = DOUBLE_WINDOW_RST;
            pressed_level = PRESSED_LEVEL_RST;
            fail_count    = 0;
            for (int b = 0; b < BUTTONS; b++)
            begin
                history[b]    = {3{~PRESSED_LEVEL_RST}};
                stable[b]     = ~PRESSED_LEVEL_RST;
                hold_cnt[b]   = '0;
                window_cnt[b] = '0;
                single_f[b]   = 1'b0;
                hold_f[b]     = 1'b0;
                double_f[b]   = 1'b0;
            end
        endfunction

        // polarity writes leave samples and debounced levels untouched
        function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_HOLD_TICKS:    hold_ticks    = data;
                REG_DOUBLE_WINDOW: window_ticks  = data;
                REG_PRESSED_LEVEL: pressed_level = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return flags_due.size();
        endfunction

        // one sampling tick: acks first, then debounce and classify
        function void note_tick(in_item_t it);
            bit [2:0]  hist;
            bit        lvl;
            bit        pressed;
            out_item_t flags;
            for (int b = 0; b < BUTTONS; b++)
            begin
                if (it.ack_single[b])
                    single_f[b] = 1'b0;
                if (it.ack_double[b])
                    double_f[b] = 1'b0;
                hist       = {history[b][1:0], it.raw_levels[b]};
                history[b] = hist;
                lvl        = hist[0];
                if (hist == 3'b000 || hist == 3'b111)
                begin
                    pressed = (lvl == pressed_level);
                    if (stable[b] != lvl)
                    begin
                        stable[b] = lvl;
                        if (pressed)
                        begin
                            hold_cnt[b] = hold_ticks;
                            if (window_cnt[b] != 0 && window_cnt[b] < window_ticks)
                            begin
                                double_f[b]   = 1'b1;
                                window_cnt[b] = '0;
                            end
                            else
                                window_cnt[b] = window_ticks;
                        end
                        else
                        begin
                            hold_f[b] = 1'b0;
                            if (window_cnt[b] != 0)
                                window_cnt[b] = window_cnt[b] - 1'b1;
                        end
                    end
                    else if (pressed)
                    begin
                        if (hold_cnt[b] != 0)
                            hold_cnt[b] = hold_cnt[b] - 1'b1;
                        if (hold_cnt[b] == 0)
                        begin
                            hold_f[b]     = 1'b1;
                            window_cnt[b] = '0;
                        end
                    end
                    else if (window_cnt[b] != 0)
                    begin
                        window_cnt[b] = window_cnt[b] - 1'b1;
                        if (window_cnt[b] == 0)
                            single_f[b] = 1'b1;
                    end
                end
                flags.single_flags[b]  = single_f[b];
                flags.hold_flags[b]    = hold_f[b];
                flags.double_flags[b]  = double_f[b];
                flags.stable_levels[b] = stable[b];
            end
            flags_due.push_back(flags);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        task compare_field(string name, logic [ITEM_BITS-1:0] got, logic [ITEM_BITS-1:0] want);
            if (got !== want)
                report($sformatf("%s got %h, wanted %h", name, got, want));
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (flags_due.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = flags_due.pop_front();
            compare_field("single_flags", got.single_flags, want.single_flags);
            compare_field("hold_flags", got.hold_flags, want.hold_flags);
            compare_field("double_flags", got.double_flags, want.double_flags);
            compare_field("stable_levels", got.stable_levels, want.stable_levels);
        endtask
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    in_item_t                  in_item   = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_item_t                 out_item;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    button_scoreboard sb = new();

    // settings of the current phase, used to size the press and release runs
    int cur_hold;
    int cur_win;
    // per-button level the sender is holding and how many ticks it has left
    bit drive_lvl [BUTTONS];
    int run_left  [BUTTONS];
    // stretches where one side never idles
    int tx_calm_left = 0;
    int rx_calm_left = 0;
    int rx_stall_left = 0;
    int idle_cycles   = 0;

    button_press_hold_double_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // sample every channel at the edge; results are checked before a new tick is
    // noted so that a stray result can never match a fresh expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_item);
            if (in_valid && in_ready)
                sb.note_tick(in_item);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
        end
    end

    // receiver: mostly ready, short stalls, now and then a long one, and calm
    // stretches with no stall at all
    always @(posedge clk)
    begin : rx_pacing
        int r;
        r = $urandom_range(0, 99);
        if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else if (rx_calm_left > 0)
        begin
            out_ready <= 1'b1;
            rx_calm_left--;
        end
        else if (r < 3)
        begin
            out_ready    <= 1'b1;
            rx_calm_left = $urandom_range(40, 150);
        end
        else if (r < 70)
            out_ready <= 1'b1;
        else if (r < 94)
        begin
            out_ready     <= 1'b0;
            rx_stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_ready     <= 1'b0;
            rx_stall_left = $urandom_range(8, 40);
        end
    end

    // watchdog: a run with no handshake for too long is a hang
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // sender gap after an item: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return 0;
        end
        if (r < 3)
        begin
            tx_calm_left = $urandom_range(30, 120);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // length of the next press or release run: short bounces, clicks that fit the
    // double window, holds long enough to flag, and plain medium runs
    function automatic int pick_run();
        int r;
        int wcap;
        int hcap;
        r    = $urandom_range(0, 99);
        wcap = (cur_win > 60) ? 60 : cur_win;
        hcap = (cur_hold > 80) ? 80 : cur_hold;
        if (r < 8)
            return $urandom_range(1, 2);
        if (r < 55)
            return $urandom_range(3, wcap + 4);
        if (r < 85)
            return $urandom_range(3, hcap + 5);
        return $urandom_range(3, 12);
    endfunction

    // raw levels of the next tick, with the odd one-tick glitch on top
    function automatic logic [ITEM_BITS-1:0] next_levels();
        logic [ITEM_BITS-1:0] lv;
        int                   idx;
        for (int b = 0; b < BUTTONS; b++)
        begin
            if (run_left[b] == 0)
            begin
                drive_lvl[b] = ~drive_lvl[b];
                run_left[b]  = pick_run();
            end
            run_left[b]--;
            lv[b] = drive_lvl[b];
        end
        if ($urandom_range(0, 99) < 4)
        begin
            idx     = $urandom_range(0, BUTTONS - 1);
            lv[idx] = ~lv[idx];
        end
        return lv;
    endfunction

    // offer one tick; valid stays up across back-to-back items and drops only
    // when a gap follows
    task automatic send_tick(input logic [ITEM_BITS-1:0] raw, input logic [ITEM_BITS-1:0] acks,
                             input logic [ITEM_BITS-1:0] ackd, input int gap);
        in_item_t it;
        it.raw_levels = raw;
        it.ack_single = acks;
        it.ack_double = ackd;
        in_item  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // every tick always yields a result, so an empty queue means the block is idle
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers only change while the block is idle; the polarity word carries
    // random upper bits that must be ignored
    task automatic apply_setup(input int hold, input int win, input bit pl);
        logic [CFG_DATA_BITS-1:0] pl_word;
        wait_drained();
        pl_word    = CFG_DATA_BITS'($urandom());
        pl_word[0] = pl;
        write_reg(REG_HOLD_TICKS, CFG_DATA_BITS'(hold));
        write_reg(REG_DOUBLE_WINDOW, CFG_DATA_BITS'(win));
        write_reg(REG_PRESSED_LEVEL, pl_word);
        cur_hold = hold;
        cur_win  = win;
    endtask

    // one phase of random ticks under one setting, with a full drain half way
    task automatic run_phase(input int hold, input int win, input bit pl, input int count);
        logic [ITEM_BITS-1:0] acks;
        logic [ITEM_BITS-1:0] ackd;
        int                   gap;
        apply_setup(hold, win, pl);
        for (int b = 0; b < BUTTONS; b++)
            run_left[b] = $urandom_range(0, 5);
        for (int n = 0; n < count; n++)
        begin
            acks = ($urandom_range(0, 99) < 25) ? ITEM_BITS'($urandom()) : '0;
            ackd = ($urandom_range(0, 99) < 25) ? ITEM_BITS'($urandom()) : '0;
            gap  = pick_gap();
            if ((n == count / 2 || n == count - 1) && gap == 0)
                gap = 1;
            send_tick(next_levels(), acks, ackd, gap);
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin : stimulus
        int gap;
        logic [ITEM_BITS-1:0] acks;
        logic [ITEM_BITS-1:0] ackd;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short counters so the directed ticks reach hold, single and double
        apply_setup(3, 5, 1'b0);
        write_reg(REG_SPARE, CFG_DATA_BITS'($urandom()));

        // all released, all pressed to hold, release, bounce-free click on two
        // buttons, second click on button 0 for a double, wait out the window
        // for a single on button 1, then acknowledge everything
        for (int k = 0; k < WARMUP_TICKS; k++)
        begin
            acks = (k == 23) ? '1 : '0;
            ackd = (k == 23 || k == 10) ? '1 : '0;
            gap  = pick_gap();
            if (k == WARMUP_TICKS - 1 && gap == 0)
                gap = 1;
            send_tick(WARMUP_LEVELS[4*(WARMUP_TICKS-1-k) +: 4], acks, ackd, gap);
        end

        run_phase(4, 8, 1'b0, 350);
        // smallest legal values: window of one can never give a double
        run_phase(1, 1, 1'b1, 250);
        // zero values: hold on the first stable pressed tick, no window at all
        run_phase(0, 0, 1'b0, 250);
        // largest values: neither counter runs out
        run_phase(65535, 65535, 1'b1, 150);
        run_phase(12, 20, 1'b1, 350);
        run_phase(6, 3, 1'b0, 300);
        run_phase($urandom_range(1, 40), $urandom_range(1, 40), 1'($urandom_range(0, 1)), 200);
        run_phase($urandom_range(1, 40), $urandom_range(1, 40), 1'($urandom_range(0, 1)), 200);

        wait_drained();
        if (sb.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
